// ===== sv/spqd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spqd_pkg
// Shared types and constants for the sorted, de-duplicating priority queue.
// ----------------------------------------------------------------------------
package spqd_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_BITS  = 16;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int FUNC_W    = 2;
  localparam int STAT_W    = 2;
  localparam int IN_KEY_W  = 16;
  localparam int PRIO_W    = 32;
  localparam int PAY_W     = 32;
  localparam int OUT_CNT_W = 7;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_POP    = 2'd2;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [PRIO_W-1:0]   prio_t;
  typedef logic [PAY_W-1:0]    pay_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef struct packed {
    key_t  key;
    prio_t prio;
    pay_t  pay;
  } entry_t;

  // per-cell compare results, sampled with the transaction
  typedef struct packed {
    logic lt;
    logic eq;
    logic km;
  } cflag_t;

  // row-wide update command
  typedef struct packed {
    logic ins;
    logic del;
    logic clr;
  } cctl_t;

endpackage

// ===== sv/sorted_priority_queue_dedup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_dedup
// Bounded priority queue kept in ascending priority order in a row of cells.
// ----------------------------------------------------------------------------
// Each operation has a compare step and an update step: on acceptance every
// cell compares its entry against the request and registers the result;
// in the busy state that follows, the row inserts, closes a gap or clears in
// a single shift and the result is registered at the output. No new
// transaction is taken while one is in flight; a result held by out_stall
// keeps in_stall high until it is taken, and the next transaction can be
// accepted in the same cycle as the waiting result. Slot contents need no
// clearing after reset: only valid bits, flags and control state are reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_dedup import spqd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [FUNC_W-1:0]           in_func,
  input  logic [IN_KEY_W-1:0]         in_item_key,
  input  logic signed [PRIO_W-1:0]    in_priority_req,
  input  logic signed [PAY_W-1:0]     in_payload,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [STAT_W-1:0]           out_status,
  output logic [IN_KEY_W-1:0]         out_key,
  output logic signed [PRIO_W-1:0]    out_priority,
  output logic signed [PAY_W-1:0]     out_payload,
  output logic [OUT_CNT_W-1:0]        out_entry_count
);

  logic              accept;
  logic              busy_r, busy_nxt;
  logic [FUNC_W-1:0] fn_r;
  entry_t            req_r;
  cnt_t              count_r, count_nxt;

  logic              ovld_r, ovld_nxt;
  logic [STAT_W-1:0] ostat_r, ostat_nxt;
  entry_t            oent_r, oent_nxt;

  entry_t                ent_w [CAPACITY];
  logic [CAPACITY-1:0]   vld_vec, lt_vec, eq_vec, km_vec;
  logic [CAPACITY-1:0]   km_from, km_first, sel_vec;
  cflag_t                flg_w [CAPACITY];
  cctl_t                 ctl;
  prio_t                 rm_prio;

  assign accept   = in_valid && !in_stall;
  assign in_stall = busy_r || (ovld_r && out_stall);

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t l_ent, r_ent;
    logic   l_vld, r_vld, l_lt;

    if (i == 0) begin : g_first
      assign l_ent = req_r;
      assign l_vld = 1'b0;
      assign l_lt  = 1'b1;
    end else begin : g_mid
      assign l_ent = ent_w[i-1];
      assign l_vld = vld_vec[i-1];
      assign l_lt  = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_ent = ent_w[i];
      assign r_vld = 1'b0;
    end else begin : g_inner
      assign r_ent = ent_w[i+1];
      assign r_vld = vld_vec[i+1];
    end

    spqd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .sample    (accept),
      .req_key   (in_item_key[KEY_BITS-1:0]),
      .req_prio  (in_priority_req),
      .ctl       (ctl),
      .left_lt   (l_lt),
      .sel       (sel_vec[i]),
      .new_ent   (req_r),
      .left_ent  (l_ent),
      .left_vld  (l_vld),
      .right_ent (r_ent),
      .right_vld (r_vld),
      .ent       (ent_w[i]),
      .vld       (vld_vec[i]),
      .flg       (flg_w[i])
    );

    assign lt_vec[i] = flg_w[i].lt;
    assign eq_vec[i] = flg_w[i].eq;
    assign km_vec[i] = flg_w[i].km;
  end

  // first key match and everything from it upwards
  assign km_from  = ~(km_vec - CAPACITY'(1)) | km_vec;
  assign km_first = km_vec & ~(km_vec - CAPACITY'(1));

  always_comb begin
    rm_prio = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rm_prio = rm_prio | (km_first[i] ? ent_w[i].prio : '0);
    end
  end

  always_comb begin
    ctl       = '0;
    sel_vec   = '0;
    count_nxt = count_r;
    busy_nxt  = busy_r;
    ovld_nxt  = ovld_r;
    ostat_nxt = ostat_r;
    oent_nxt  = oent_r;
    if (ovld_r && !out_stall) begin
      ovld_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (busy_r) begin
      busy_nxt  = 1'b0;
      ovld_nxt  = 1'b1;
      ostat_nxt = ST_DONE;
      oent_nxt  = '0;
      unique case (fn_r)
        FN_INSERT: begin
          if (|eq_vec) begin
            ostat_nxt = ST_DUP;
          end else if (count_r == CNT_W'(CAPACITY)) begin
            ostat_nxt = ST_FULL;
          end else begin
            ctl.ins   = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        FN_REMOVE: begin
          if (|km_vec) begin
            ctl.del       = 1'b1;
            sel_vec       = km_from;
            oent_nxt.prio = rm_prio;
            count_nxt     = count_r - CNT_W'(1);
          end else begin
            ostat_nxt = ST_MISS;
          end
        end
        FN_POP: begin
          if (count_r != '0) begin
            ctl.del   = 1'b1;
            sel_vec   = '1;
            oent_nxt  = ent_w[0];
            count_nxt = count_r - CNT_W'(1);
          end else begin
            ostat_nxt = ST_MISS;
          end
        end
        FN_CLEAR: begin
          ctl.clr   = 1'b1;
          count_nxt = '0;
        end
        default: begin
          ostat_nxt = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      count_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      count_r <= count_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ostat_r <= ostat_nxt;
    oent_r  <= oent_nxt;
    if (accept) begin
      fn_r     <= in_func;
      req_r    <= '{key: in_item_key[KEY_BITS-1:0], prio: in_priority_req, pay: in_payload};
    end
  end

  assign out_valid       = ovld_r;
  assign out_status      = ostat_r;
  assign out_key         = IN_KEY_W'(oent_r.key);
  assign out_priority    = oent_r.prio;
  assign out_payload     = oent_r.pay;
  assign out_entry_count = OUT_CNT_W'(count_r);

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == int'(count_r))
    else $error("valid bits disagree with entry count");

  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_vec & (vld_vec + CAPACITY'(1))) == '0)
    else $error("valid slots not packed from slot 0");

  a_result_after_op: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovld_r) |-> $past(busy_r))
    else $error("result produced without a transaction in flight");

endmodule

// ===== sv/spqd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spqd_cell
// One slot of the sorted row: holds an entry, compares it against the
// request and shifts to or from its neighbours.
// ----------------------------------------------------------------------------
module spqd_cell import spqd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   sample,
  input  key_t   req_key,
  input  prio_t  req_prio,
  input  cctl_t  ctl,
  input  logic   left_lt,
  input  logic   sel,
  input  entry_t new_ent,
  input  entry_t left_ent,
  input  logic   left_vld,
  input  entry_t right_ent,
  input  logic   right_vld,
  output entry_t ent,
  output logic   vld,
  output cflag_t flg
);

  entry_t ent_r, ent_nxt;
  logic   vld_r, vld_nxt;
  cflag_t flg_r, flg_nxt;

  always_comb begin
    flg_nxt = flg_r;
    if (sample) begin
      flg_nxt.lt = vld_r && ($signed(ent_r.prio) < $signed(req_prio));
      flg_nxt.eq = vld_r && (ent_r.prio == req_prio);
      flg_nxt.km = vld_r && (ent_r.key == req_key);
    end
  end

  always_comb begin
    ent_nxt = ent_r;
    vld_nxt = vld_r;
    if (ctl.clr) begin
      vld_nxt = 1'b0;
    end else if (ctl.ins && !flg_r.lt) begin
      if (left_lt) begin
        ent_nxt = new_ent;
        vld_nxt = 1'b1;
      end else begin
        ent_nxt = left_ent;
        vld_nxt = left_vld;
      end
    end else if (ctl.del && sel) begin
      ent_nxt = right_ent;
      vld_nxt = right_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      flg_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      flg_r <= flg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;
  assign vld = vld_r;
  assign flg = flg_r;

endmodule
